// ----- rtl/mmpd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmpd_pkg
// Shared types and constants for the min/max pixel decimator.
// ----------------------------------------------------------------------------
package mmpd_pkg;

  typedef enum logic [1:0] {
    PH_BEFORE,
    PH_INSIDE,
    PH_DONE
  } phase_e;

  localparam logic [1:0] REG_X_ORIGIN        = 2'd0;
  localparam logic [1:0] REG_PIXELS_PER_UNIT = 2'd1;
  localparam logic [1:0] REG_UNITS_PER_PIXEL = 2'd2;
  localparam logic [1:0] REG_CANVAS_WIDTH    = 2'd3;

  localparam int COL_FULL_W = 28;
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_PTR_W = 3;
  localparam int FIFO_CNT_W = 4;
  localparam int MAX_PUSH   = 3;

  typedef struct packed {
    logic [31:0] x_origin;
    logic [31:0] pixels_per_unit;
    logic [31:0] units_per_pixel;
    logic [12:0] canvas_width;
  } cfg_t;

  typedef struct packed {
    logic [31:0]        x;
    logic signed [31:0] y;
    logic               last;
  } point_t;

  typedef struct packed {
    logic [31:0]           x;
    logic signed [31:0]    y;
    logic                  last;
    logic                  left;
    logic [COL_FULL_W-1:0] col;
    logic                  col_ge_w;
    logic [31:0]           col_edge;
  } item_t;

endpackage

// ----- rtl/mmpd_map.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmpd_map
// Column mapping pipeline: offset, scale to column, column edge x.
// ----------------------------------------------------------------------------
module mmpd_map
  import mmpd_pkg::*;
#(
  parameter int MAX_COLUMNS = 4096
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               adv_i,
  input  logic               in_valid_i,
  input  logic [31:0]        sample_x_i,
  input  logic signed [31:0] sample_y_i,
  input  logic               last_sample_i,
  input  cfg_t               cfg_i,
  output logic               out_valid_o,
  output item_t              out_item_o
);

  localparam int CUR_W = ($clog2(MAX_COLUMNS) < 13) ? $clog2(MAX_COLUMNS) : 13;
  localparam int EP_W  = CUR_W + 32;

  // stage 1
  logic               s1_v_q;
  logic [31:0]        s1_x_q;
  logic signed [31:0] s1_y_q;
  logic               s1_last_q, s1_left_q, s1_ge_q;
  logic [31:0]        s1_diff_q;

  // stage 2..4
  logic               s2_v_q, s3_v_q, s4_v_q;
  item_t              s2_q, s3_q, s4_q;
  logic [EP_W-1:0]    s3_eprod_q;

  logic [63:0]        s2_prod;
  logic [EP_W:0]      s4_sum;

  assign s2_prod = 64'(s1_diff_q) * 64'(cfg_i.pixels_per_unit);
  assign s4_sum  = (EP_W+1)'(cfg_i.x_origin) + (EP_W+1)'(s3_eprod_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
    end else if (adv_i) begin
      s1_v_q <= in_valid_i;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
      s4_v_q <= s3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s1_x_q    <= sample_x_i;
      s1_y_q    <= sample_y_i;
      s1_last_q <= last_sample_i;
      s1_left_q <= (sample_x_i < cfg_i.x_origin) && (cfg_i.pixels_per_unit != 32'd0);
      s1_ge_q   <= (sample_x_i >= cfg_i.x_origin);
      s1_diff_q <= sample_x_i - cfg_i.x_origin;

      s2_q <= '{x:        s1_x_q,
                y:        s1_y_q,
                last:     s1_last_q,
                left:     s1_left_q,
                col:      s1_ge_q ? s2_prod[63:36] : '0,
                col_ge_w: 1'b0,
                col_edge: '0};

      s3_q <= '{x:        s2_q.x,
                y:        s2_q.y,
                last:     s2_q.last,
                left:     s2_q.left,
                col:      s2_q.col,
                col_ge_w: (s2_q.col >= COL_FULL_W'(cfg_i.canvas_width)) ||
                          (s2_q.col >= COL_FULL_W'(MAX_COLUMNS)),
                col_edge: '0};
      s3_eprod_q <= EP_W'(s2_q.col[CUR_W-1:0]) * EP_W'(cfg_i.units_per_pixel);

      s4_q <= '{x:        s3_q.x,
                y:        s3_q.y,
                last:     s3_q.last,
                left:     s3_q.left,
                col:      s3_q.col,
                col_ge_w: s3_q.col_ge_w,
                col_edge: (|s4_sum[EP_W:32]) ? 32'hFFFF_FFFF : s4_sum[31:0]};
    end
  end

  assign out_valid_o = s4_v_q;
  assign out_item_o  = s4_q;

endmodule

// ----- rtl/mmpd_col.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmpd_col
// Run and column tracker: min/max per column, emits up to three points.
// ----------------------------------------------------------------------------
module mmpd_col
  import mmpd_pkg::*;
#(
  parameter int MAX_COLUMNS = 4096
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     adv_i,
  input  logic                     in_valid_i,
  input  item_t                    item_i,
  output logic [1:0]               push_n_o,
  output point_t [MAX_PUSH-1:0]    push_pts_o
);

  localparam int CUR_W = ($clog2(MAX_COLUMNS) < 13) ? $clog2(MAX_COLUMNS) : 13;

  phase_e             phase_q, phase_d;
  logic               prev_valid_q, prev_valid_d;
  logic [31:0]        prev_x_q, prev_x_d;
  logic signed [31:0] prev_y_q, prev_y_d;
  logic [CUR_W-1:0]   cur_col_q, cur_col_d;
  logic signed [31:0] col_min_q, col_min_d, col_max_q, col_max_d;
  logic [1:0]         col_cnt_q, col_cnt_d;
  logic [31:0]        single_x_q, single_x_d;
  logic signed [31:0] single_y_q, single_y_d;
  logic [31:0]        col_edge_q, col_edge_d;

  logic   fire, joins, flush, tail_v;
  logic [1:0] head_n;
  point_t h0, h1, tail;

  assign fire  = adv_i && in_valid_i;
  assign joins = item_i.left || (item_i.col <= COL_FULL_W'(cur_col_q));

  // next state
  always_comb begin
    phase_d      = phase_q;
    prev_valid_d = prev_valid_q;
    prev_x_d     = prev_x_q;
    prev_y_d     = prev_y_q;
    cur_col_d    = cur_col_q;
    col_min_d    = col_min_q;
    col_max_d    = col_max_q;
    col_cnt_d    = col_cnt_q;
    single_x_d   = single_x_q;
    single_y_d   = single_y_q;
    col_edge_d   = col_edge_q;
    if (fire) begin
      unique case (phase_q)
        PH_BEFORE: begin
          if (item_i.last) begin
            phase_d      = PH_BEFORE;
            prev_valid_d = 1'b0;
            col_cnt_d    = 2'd0;
          end else if (item_i.left) begin
            prev_x_d     = item_i.x;
            prev_y_d     = item_i.y;
            prev_valid_d = 1'b1;
          end else if (item_i.col_ge_w) begin
            phase_d = PH_DONE;
          end else begin
            phase_d    = PH_INSIDE;
            cur_col_d  = item_i.col[CUR_W-1:0];
            col_cnt_d  = 2'd1;
            col_min_d  = item_i.y;
            col_max_d  = item_i.y;
            single_x_d = item_i.x;
            single_y_d = item_i.y;
            col_edge_d = item_i.col_edge;
          end
        end
        PH_INSIDE: begin
          if (item_i.last) begin
            phase_d      = PH_BEFORE;
            prev_valid_d = 1'b0;
            col_cnt_d    = 2'd0;
          end else if (joins) begin
            if (item_i.y < col_min_q) col_min_d = item_i.y;
            if (item_i.y > col_max_q) col_max_d = item_i.y;
            if (col_cnt_q < 2'd2) col_cnt_d = col_cnt_q + 2'd1;
          end else if (item_i.col_ge_w) begin
            phase_d   = PH_DONE;
            col_cnt_d = 2'd0;
          end else begin
            cur_col_d  = item_i.col[CUR_W-1:0];
            col_cnt_d  = 2'd1;
            col_min_d  = item_i.y;
            col_max_d  = item_i.y;
            single_x_d = item_i.x;
            single_y_d = item_i.y;
            col_edge_d = item_i.col_edge;
          end
        end
        PH_DONE: begin
          if (item_i.last) begin
            phase_d      = PH_BEFORE;
            prev_valid_d = 1'b0;
            col_cnt_d    = 2'd0;
          end
        end
        default: phase_d = PH_BEFORE;
      endcase
    end
  end

  // outputs
  always_comb begin
    flush  = 1'b0;
    tail_v = 1'b0;
    head_n = 2'd0;
    h0     = '0;
    h1     = '0;
    tail   = '{x: item_i.x, y: item_i.y, last: 1'b1};
    if (fire) begin
      unique case (phase_q)
        PH_BEFORE: begin
          if (item_i.last || !item_i.left) begin
            if (prev_valid_q) begin
              head_n = 2'd1;
              h0     = '{x: prev_x_q, y: prev_y_q, last: 1'b0};
            end
            tail_v = item_i.last ? prev_valid_q : item_i.col_ge_w;
          end
        end
        PH_INSIDE: begin
          if (item_i.last) begin
            flush  = 1'b1;
            tail_v = 1'b1;
          end else if (!joins) begin
            flush  = 1'b1;
            tail_v = item_i.col_ge_w;
          end
        end
        PH_DONE: ;
        default: ;
      endcase
    end
    if (flush) begin
      if (col_cnt_q == 2'd1) begin
        head_n = 2'd1;
        h0     = '{x: single_x_q, y: single_y_q, last: 1'b0};
      end else if (col_cnt_q >= 2'd2) begin
        head_n = 2'd2;
        h0     = '{x: col_edge_q, y: col_min_q, last: 1'b0};
        h1     = '{x: col_edge_q, y: col_max_q, last: 1'b0};
      end
    end
    push_pts_o[0] = h0;
    push_pts_o[1] = h1;
    push_pts_o[2] = tail;
    unique case (head_n)
      2'd0:    push_pts_o[0] = tail;
      2'd1:    push_pts_o[1] = tail;
      default: ;
    endcase
    push_n_o = head_n + {1'b0, tail_v};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_BEFORE;
      prev_valid_q <= 1'b0;
      col_cnt_q    <= 2'd0;
    end else begin
      phase_q      <= phase_d;
      prev_valid_q <= prev_valid_d;
      col_cnt_q    <= col_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prev_x_q   <= prev_x_d;
    prev_y_q   <= prev_y_d;
    cur_col_q  <= cur_col_d;
    col_min_q  <= col_min_d;
    col_max_q  <= col_max_d;
    single_x_q <= single_x_d;
    single_y_q <= single_y_d;
    col_edge_q <= col_edge_d;
  end

endmodule

// ----- rtl/mmpd_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmpd_fifo
// Point queue: up to three writes per cycle, one read.
// ----------------------------------------------------------------------------
module mmpd_fifo
  import mmpd_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [1:0]            push_n_i,
  input  point_t [MAX_PUSH-1:0] push_pts_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output point_t                out_pt_o,
  output logic [FIFO_CNT_W-1:0] level_o
);

  point_t                mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [FIFO_CNT_W-1:0] level_q;
  logic                  pop;

  assign out_valid_o = (level_q != '0);
  assign pop         = out_valid_o && !out_stall_i;
  assign out_pt_o    = mem_q[rd_ptr_q];
  assign level_o     = level_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(push_n_i);
      rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(pop);
      level_q  <= level_q + FIFO_CNT_W'(push_n_i) - FIFO_CNT_W'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MAX_PUSH; i++) begin
      if (2'(i) < push_n_i) begin
        mem_q[wr_ptr_q + FIFO_PTR_W'(i)] <= push_pts_i[i];
      end
    end
  end

endmodule

// ----- rtl/minmax_pixel_decimator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// minmax_pixel_decimator
// Min/max peak-detect decimation of a spectrum onto pixel columns.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake                   Payload
// sample    in         sample_valid_i/sample_stall_o sample_x_i, sample_y_i, last_sample_i
// point     out        point_valid_o/point_stall_i  point_x_o, point_y_o, last_point_o
// config    in         cfg_we_i                     cfg_index_i, cfg_data_i
//
// One sample accepted per cycle while sample_stall_o is low; its points pass the map
// stages s1 to s4, are written into the point queue and can leave it in the cycle after.
// A sample gives 0 to 3 points; the queue drains one point per cycle while point_stall_i is low.
// Input stalls while the eight-entry point queue has fewer than three free slots.
// Reset clears the run state; there is no clearing pass.
// ----------------------------------------------------------------------------
module minmax_pixel_decimator
  import mmpd_pkg::*;
#(
  parameter int MAX_COLUMNS = 4096
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               sample_valid_i,
  output logic               sample_stall_o,
  input  logic [31:0]        sample_x_i,
  input  logic signed [31:0] sample_y_i,
  input  logic               last_sample_i,
  output logic               point_valid_o,
  input  logic               point_stall_i,
  output logic [31:0]        point_x_o,
  output logic signed [31:0] point_y_o,
  output logic               last_point_o,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i
);

  cfg_t                  cfg_q;
  logic                  adv;
  logic                  map_valid;
  item_t                 map_item;
  logic [1:0]            push_n;
  point_t [MAX_PUSH-1:0] push_pts;
  point_t                out_pt;
  logic [FIFO_CNT_W-1:0] level;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.x_origin        <= 32'd0;
      cfg_q.pixels_per_unit <= 32'd16777216;
      cfg_q.units_per_pixel <= 32'd4096;
      cfg_q.canvas_width    <= 13'd1024;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_X_ORIGIN:        cfg_q.x_origin        <= cfg_data_i;
        REG_PIXELS_PER_UNIT: cfg_q.pixels_per_unit <= cfg_data_i;
        REG_UNITS_PER_PIXEL: cfg_q.units_per_pixel <= cfg_data_i;
        REG_CANVAS_WIDTH:    cfg_q.canvas_width    <= cfg_data_i[12:0];
        default: ;
      endcase
    end
  end

  assign adv            = (level <= FIFO_CNT_W'(FIFO_DEPTH - MAX_PUSH));
  assign sample_stall_o = !adv;

  mmpd_map #(
    .MAX_COLUMNS(MAX_COLUMNS)
  ) u_map (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .adv_i        (adv),
    .in_valid_i   (sample_valid_i),
    .sample_x_i   (sample_x_i),
    .sample_y_i   (sample_y_i),
    .last_sample_i(last_sample_i),
    .cfg_i        (cfg_q),
    .out_valid_o  (map_valid),
    .out_item_o   (map_item)
  );

  mmpd_col #(
    .MAX_COLUMNS(MAX_COLUMNS)
  ) u_col (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (adv),
    .in_valid_i(map_valid),
    .item_i    (map_item),
    .push_n_o  (push_n),
    .push_pts_o(push_pts)
  );

  mmpd_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_n_i   (push_n),
    .push_pts_i (push_pts),
    .out_valid_o(point_valid_o),
    .out_stall_i(point_stall_i),
    .out_pt_o   (out_pt),
    .level_o    (level)
  );

  assign point_x_o    = out_pt.x;
  assign point_y_o    = out_pt.y;
  assign last_point_o = out_pt.last;

  a_level_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    level <= FIFO_CNT_W'(FIFO_DEPTH))
    else $error("point queue overflow");

  a_no_push_on_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |-> (push_n == 2'd0))
    else $error("points pushed while pipeline held");

  a_valid_from_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(point_valid_o) |-> $past(push_n != 2'd0))
    else $error("point appeared without a push");

endmodule

// ----- bench/mmpd_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmpd_checker
// Watches the sample, point and register ports of the min/max pixel
// decimator, keeps its own copy of the decimation state, predicts the points
// each accepted sample request produces and compares them in order.
// ----------------------------------------------------------------------------
module mmpd_checker
  import mmpd_pkg::*;
#(
  parameter int MAX_COLUMNS = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        sample_valid_i,
  input  logic        sample_stall_i,
  input  logic [31:0] sample_x_i,
  input  logic [31:0] sample_y_i,
  input  logic        last_sample_i,
  input  logic        point_valid_i,
  input  logic        point_stall_i,
  input  logic [31:0] point_x_i,
  input  logic [31:0] point_y_i,
  input  logic        last_point_i,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  output int          fail_count_o,
  output int          pending_o
);

  logic [31:0]        x_origin;
  logic [31:0]        pixels_per_unit;
  logic [31:0]        units_per_pixel;
  logic [12:0]        canvas_width;

  phase_e             run_phase;
  logic [31:0]        held_x;
  logic [31:0]        held_y;
  logic               held_ok;
  logic [31:0]        open_col;
  logic signed [31:0] col_min;
  logic signed [31:0] col_max;
  logic [1:0]         col_count;
  logic [31:0]        lone_x;
  logic [31:0]        lone_y;

  point_t             expected_points[$];
  int                 mismatches;
  int                 outstanding;

  assign fail_count_o = mismatches;
  assign pending_o    = outstanding;

  task automatic queue_point(input logic [31:0] x, input logic [31:0] y, input logic last);
    point_t p;
    p.x    = x;
    p.y    = y;
    p.last = last;
    expected_points.push_back(p);
  endtask

  task automatic clear_run();
    run_phase = PH_BEFORE;
    held_x    = '0;
    held_y    = '0;
    held_ok   = 1'b0;
    open_col  = '0;
    col_min   = '0;
    col_max   = '0;
    col_count = '0;
    lone_x    = '0;
    lone_y    = '0;
  endtask

  task automatic open_column(input logic [31:0] col, input logic [31:0] x,
                             input logic [31:0] y);
    open_col  = col;
    col_count = 2'd1;
    col_min   = y;
    col_max   = y;
    lone_x    = x;
    lone_y    = y;
  endtask

  task automatic close_column();
    logic [63:0] left_x;
    if (col_count == 2'd1) begin
      queue_point(lone_x, lone_y, 1'b0);
    end else if (col_count >= 2'd2) begin
      left_x = {32'd0, x_origin} + {32'd0, open_col} * {32'd0, units_per_pixel};
      if (left_x > 64'h0000_0000_FFFF_FFFF) left_x = 64'h0000_0000_FFFF_FFFF;
      queue_point(left_x[31:0], col_min, 1'b0);
      queue_point(left_x[31:0], col_max, 1'b0);
    end
    col_count = 2'd0;
  endtask

  task automatic predict_points(input logic [31:0] x, input logic [31:0] y,
                                input logic last);
    logic [31:0]        width;
    logic               left;
    logic [63:0]        col;
    logic signed [31:0] ys;
    width = (canvas_width > MAX_COLUMNS) ? MAX_COLUMNS : canvas_width;
    left  = (x < x_origin) && (pixels_per_unit != 0);
    ys    = y;
    col   = '0;
    if (!left && x >= x_origin)
      col = ({32'd0, x - x_origin} * {32'd0, pixels_per_unit}) >> 36;

    case (run_phase)
      PH_BEFORE: begin
        if (last) begin
          if (held_ok) begin
            queue_point(held_x, held_y, 1'b0);
            queue_point(x, y, 1'b1);
          end
          clear_run();
        end else if (left) begin
          held_x  = x;
          held_y  = y;
          held_ok = 1'b1;
        end else begin
          if (held_ok) queue_point(held_x, held_y, 1'b0);
          if (col >= width) begin
            queue_point(x, y, 1'b1);
            run_phase = PH_DONE;
          end else begin
            open_column(col[31:0], x, y);
            run_phase = PH_INSIDE;
          end
        end
      end
      PH_INSIDE: begin
        if (last) begin
          close_column();
          queue_point(x, y, 1'b1);
          clear_run();
        end else if (left || col <= {32'd0, open_col}) begin
          if (ys < col_min) col_min = ys;
          if (ys > col_max) col_max = ys;
          if (col_count < 2'd2) col_count = col_count + 2'd1;
        end else begin
          close_column();
          if (col >= width) begin
            queue_point(x, y, 1'b1);
            run_phase = PH_DONE;
          end else begin
            open_column(col[31:0], x, y);
          end
        end
      end
      default: begin
        if (last) clear_run();
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    point_t want;
    if (!rst_ni) begin
      x_origin        = 32'd0;
      pixels_per_unit = 32'd16777216;
      units_per_pixel = 32'd4096;
      canvas_width    = 13'd1024;
      clear_run();
      expected_points.delete();
    end else begin
      // compare first: a point leaving now cannot come from a request taken now
      if (point_valid_i && !point_stall_i) begin
        if (expected_points.size() == 0) begin
          $error("unexpected point: x=%h y=%h last=%b", point_x_i, point_y_i, last_point_i);
          mismatches++;
        end else begin
          want = expected_points.pop_front();
          if (point_x_i !== want.x) begin
            $error("point_x mismatch: expected %h, actual %h", want.x, point_x_i);
            mismatches++;
          end
          if (point_y_i !== want.y) begin
            $error("point_y mismatch: expected %h, actual %h", want.y, point_y_i);
            mismatches++;
          end
          if (last_point_i !== want.last) begin
            $error("last_point mismatch: expected %b, actual %b", want.last, last_point_i);
            mismatches++;
          end
        end
      end

      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_X_ORIGIN:        x_origin        = cfg_data_i;
          REG_PIXELS_PER_UNIT: pixels_per_unit = cfg_data_i;
          REG_UNITS_PER_PIXEL: units_per_pixel = cfg_data_i;
          REG_CANVAS_WIDTH:    canvas_width    = cfg_data_i[12:0];
          default: ;
        endcase
      end

      if (sample_valid_i && !sample_stall_i)
        predict_points(sample_x_i, sample_y_i, last_sample_i);
    end
    outstanding = expected_points.size();
  end

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives sample requests into the min/max pixel decimator: a directed pass
// over the corner cases, then register settings with random spectrum and noise runs.
// Sender bursts and receiver stalls are random; the checker does the compare.
// ----------------------------------------------------------------------------
module tb;
  import mmpd_pkg::*;

  localparam int     CYCLE_LIMIT = 200000;
  localparam longint X_TOP       = 64'h0000_0000_FFFF_FFFF;

  logic        clk          = 1'b0;
  logic        rst_n        = 1'b0;
  logic        sample_valid = 1'b0;
  logic        sample_stall;
  logic [31:0] sample_x     = '0;
  logic [31:0] sample_y     = '0;
  logic        last_sample  = 1'b0;
  logic        point_valid;
  logic        point_stall  = 1'b0;
  logic [31:0] point_x;
  logic [31:0] point_y;
  logic        last_point;
  logic        cfg_we       = 1'b0;
  logic [1:0]  cfg_index    = '0;
  logic [31:0] cfg_data     = '0;

  int          fail_count;
  int          pending_points;
  int          cycle_count;
  int          requests_sent;
  int          burst_left;
  bit          valid_up;
  int          stall_mode;
  int          stall_left;
  logic [31:0] xo_cur;
  longint      col_span;

  minmax_pixel_decimator DUT (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .sample_valid_i (sample_valid),
    .sample_stall_o (sample_stall),
    .sample_x_i     (sample_x),
    .sample_y_i     (sample_y),
    .last_sample_i  (last_sample),
    .point_valid_o  (point_valid),
    .point_stall_i  (point_stall),
    .point_x_o      (point_x),
    .point_y_o      (point_y),
    .last_point_o   (last_point),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  mmpd_checker u_point_check (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .sample_valid_i (sample_valid),
    .sample_stall_i (sample_stall),
    .sample_x_i     (sample_x),
    .sample_y_i     (sample_y),
    .last_sample_i  (last_sample),
    .point_valid_i  (point_valid),
    .point_stall_i  (point_stall),
    .point_x_i      (point_x),
    .point_y_i      (point_y),
    .last_point_i   (last_point),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .fail_count_o   (fail_count),
    .pending_o      (pending_points)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // receiver: free, light, heavy and long-block stall modes
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(5, 60);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0:       point_stall <= 1'b0;
      1:       point_stall <= ($urandom_range(0, 3) == 0);
      2:       point_stall <= ($urandom_range(0, 3) != 0);
      default: point_stall <= ((stall_left % 16) < 10);
    endcase
  end

  task automatic send_sample(input logic [31:0] x, input logic [31:0] y, input logic last);
    sample_x     <= x;
    sample_y     <= y;
    last_sample  <= last;
    sample_valid <= 1'b1;
    valid_up = 1'b1;
    do @(posedge clk); while (sample_stall);
    requests_sent++;
    if (burst_left == 0) begin
      sample_valid <= 1'b0;
      valid_up = 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? 60 : $urandom_range(0, 15);
    end else begin
      burst_left--;
    end
  endtask

  task automatic quiesce();
    if (valid_up) begin
      sample_valid <= 1'b0;
      valid_up = 1'b0;
    end
    while (pending_points != 0) @(posedge clk);
    // requests that make no point may still be in the pipe
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  task automatic configure(input logic [31:0] xo, input logic [31:0] ppu,
                           input logic [31:0] upp, input logic [12:0] cw);
    quiesce();
    write_reg(REG_X_ORIGIN, xo);
    write_reg(REG_PIXELS_PER_UNIT, ppu);
    write_reg(REG_UNITS_PER_PIXEL, upp);
    write_reg(REG_CANVAS_WIDTH, {19'd0, cw});
    cfg_we <= 1'b0;
    xo_cur   = xo;
    col_span = (ppu == 0) ? 64'd4096 : (64'd1 << 36) / ppu;
    if (col_span > 64'h8000_0000) col_span = 64'h8000_0000;
    if (col_span < 1) col_span = 1;
  endtask

  function automatic logic [31:0] rand_y();
    case ($urandom_range(0, 5))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  // well-formed spectrum: start near the origin or at a random x, mostly ascending x
  task automatic run_spectrum(input int n);
    longint x;
    longint step_max;
    int     i;
    int     pick;
    step_max = col_span * 3 / 2;
    pick = $urandom_range(0, 3);
    if (pick == 0) x = longint'($urandom);
    else if (pick == 1) x = longint'(xo_cur);
    else x = longint'(xo_cur) - longint'($urandom_range(0, 1023)) * col_span * 2 / 1024;
    if (x < 0) x = 0;
    for (i = 0; i < n; i++) begin
      send_sample(x[31:0], rand_y(), i == n - 1);
      pick = $urandom_range(0, 19);
      if (pick == 0) x = x - longint'($urandom_range(0, 255)) * col_span / 256;
      else if (pick == 1) x = x + longint'($urandom);
      else x = x + longint'($urandom_range(0, 1023)) * step_max / 1024;
      if (x < 0) x = 0;
      else if (x > X_TOP) x = X_TOP;
    end
  endtask

  task automatic run_noise(input int n);
    int i;
    for (i = 0; i < n; i++)
      send_sample($urandom, rand_y(), (i == n - 1) || ($urandom_range(0, 5) == 0));
  endtask

  initial begin
    int phase_no;
    int phase_start;
    int random_start;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // origin 16.0, one column per unit, eight columns
    configure(32'h0001_0000, 32'h0100_0000, 32'd4096, 13'd8);
    send_sample(32'h0000_5000, 32'd1, 1'b1);
    send_sample(32'h0000_0000, 32'h7FFF_FFFF, 1'b0);
    send_sample(32'h0000_8000, 32'h8000_0000, 1'b0);
    send_sample(32'h0000_9000, -32'sd5, 1'b1);
    send_sample(32'h0000_F000, 32'd7, 1'b0);
    send_sample(32'h0001_0000, 32'd3, 1'b0);
    send_sample(32'h0001_0800, 32'h8000_0000, 1'b0);
    send_sample(32'h0001_0C00, 32'h7FFF_FFFF, 1'b0);
    send_sample(32'h0001_1000, 32'd9, 1'b0);
    send_sample(32'h0001_2400, -32'sd1, 1'b0);
    send_sample(32'h0001_2000, 32'd4, 1'b0);
    send_sample(32'h0001_1000, -32'sd100, 1'b0);
    send_sample(32'h0001_5000, 32'd0, 1'b0);
    send_sample(32'h0001_8000, 32'd11, 1'b0);
    send_sample(32'h0001_9000, 32'd12, 1'b0);
    send_sample(32'h0001_A000, 32'd13, 1'b1);
    send_sample(32'h0001_0000, 32'd1, 1'b0);
    send_sample(32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b1);

    // zero canvas: any in-range sample ends the run
    configure(32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 13'd0);
    send_sample(32'h0000_0000, 32'd5, 1'b0);
    send_sample(32'hFFFF_FFFF, 32'd6, 1'b1);

    // zero scale: everything lands in column zero
    configure(32'h8000_0000, 32'd0, 32'd0, 13'd1);
    send_sample(32'h0000_0003, 32'd1, 1'b0);
    send_sample(32'hFFFF_FFFF, -32'sd2, 1'b0);
    send_sample(32'h8000_0000, 32'd2, 1'b0);
    send_sample(32'h0000_0005, 32'd8, 1'b1);

    // full scale with a saturating column edge
    configure(32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 13'd4096);
    send_sample(32'h0000_0100, 32'd1, 1'b0);
    send_sample(32'h0000_0101, 32'd2, 1'b0);
    send_sample(32'h0000_0300, 32'd3, 1'b1);

    random_start = requests_sent;
    phase_no = 0;
    while (requests_sent - random_start < 72) begin
      case (phase_no % 6)
        0: configure(32'd0, 32'h0100_0000, 32'd0, 13'd4096);
        1: configure($urandom, 32'h0100_0000, 32'd4096, 13'($urandom_range(2, 16)));
        2: configure($urandom, 32'hFFFF_FFFF, 32'd16, 13'd8191);
        3: configure($urandom_range(0, 32'h0010_0000), 32'h1000_0000, 32'hFFFF_FFFF,
                     13'($urandom_range(1, 6)));
        4: configure($urandom, 32'd0, $urandom, 13'($urandom_range(0, 3)));
        default: configure($urandom, $urandom, $urandom, 13'($urandom_range(0, 8191)));
      endcase
      phase_start = requests_sent;
      while (requests_sent - phase_start < 12) begin
        if ($urandom_range(0, 5) == 0) run_noise($urandom_range(2, 8));
        else run_spectrum($urandom_range(2, 12));
      end
      phase_no++;
    end

    quiesce();
    repeat (20) @(posedge clk);
    if (fail_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
